>>> rtl/ktp_pkg.sv
// Shared constants and codes for the keyword to permutation block.
package ktp_pkg;

  localparam int MAX_LETTERS = 26;
  localparam int IDX_W       = 5;
  localparam int LET_W       = 5;
  localparam int ST_W        = 2;
  localparam int ADDR_W      = $clog2(MAX_LETTERS);

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_NUMERIC = 2'd2;

  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_D0 = 8'h30;
  localparam logic [7:0] CH_D9 = 8'h39;

endpackage

>>> rtl/ktp_in_if.sv
// Key byte channel: valid, ready and one key byte item.
interface ktp_in_if;
  import ktp_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       end_of_key;

  modport source (output valid, output char_code, output has_char, output end_of_key,
                  input ready);
  modport sink   (input valid, input char_code, input has_char, input end_of_key,
                  output ready);
endinterface

>>> rtl/ktp_out_if.sv
// Permutation result channel: valid, ready and one result item.
interface ktp_out_if;
  import ktp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] position;
  logic [IDX_W-1:0] forward_value;
  logic [IDX_W-1:0] inverse_value;
  logic [IDX_W-1:0] perm_length;
  logic [ST_W-1:0]  status;
  logic             last_result;

  modport source (output valid, output position, output forward_value,
                  output inverse_value, output perm_length, output status,
                  output last_result, input ready);
  modport sink   (input valid, input position, input forward_value,
                  input inverse_value, input perm_length, input status,
                  input last_result, output ready);
endinterface

>>> rtl/ktp_ram.sv
// Generic single port RAM with registered read.
module ktp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/keyword_to_permutation_top.sv
// Top level: key collection, permutation unranking and result emission.
//
//  channel | dir | payload
//  in_ch   | in  | char_code, has_char, end_of_key
//  out_ch  | out | position, forward_value, inverse_value, perm_length, status, last_result
//
// The block takes key bytes only while idle, not while a key is being unranked or its results sent.
// Per kept letter: fetch it from the letter RAM (read, load), a modulo by compare and
// subtract, then a scan of the used-index vector.
// Each result then takes a fwd/inv RAM read and an output load; empty/numeric keys a single load.
// Reset (synchronous, rst_n low) clears control state; RAM contents stay undefined.
// A stalled output holds its item; the next key is taken while the last result waits.
module keyword_to_permutation_top (
  input logic clk,
  input logic rst_n,
  ktp_in_if.sink    in_ch,
  ktp_out_if.source out_ch
);
  import ktp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_LD     = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_ORD    = 3'd5;
  localparam logic [2:0] S_OLOAD  = 3'd6;
  localparam logic [2:0] S_SINGLE = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic                   first_r, first_nxt;
  logic                   digit_r, digit_nxt;
  logic [IDX_W-1:0]       n_r, n_nxt;
  logic [IDX_W-1:0]       i_r, i_nxt;
  logic [IDX_W-1:0]       left_r, left_nxt;
  logic [LET_W-1:0]       v_r, v_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [MAX_LETTERS-1:0] used_r, used_nxt;
  logic [ST_W-1:0]        st_r, st_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       out_pos_r, out_pos_nxt;
  logic [IDX_W-1:0]       out_fwd_r, out_fwd_nxt;
  logic [IDX_W-1:0]       out_inv_r, out_inv_nxt;
  logic [IDX_W-1:0]       out_len_r, out_len_nxt;
  logic [ST_W-1:0]        out_st_r, out_st_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_acc;
  logic                   slot_free;
  logic                   is_upper, is_lower, is_digit, keep;
  logic [7:0]             let_full;
  logic [IDX_W-1:0]       cnt_new;
  logic                   dig_new;
  logic [IDX_W-1:0]       i_inc;

  logic                   let_we, fwd_we, inv_we;
  logic [ADDR_W-1:0]      let_addr, inv_addr;
  logic [LET_W-1:0]       let_rdata;
  logic [IDX_W-1:0]       fwd_rdata, inv_rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign i_inc       = i_r + IDX_W'(1);

  always_comb begin
    is_upper = in_ch.char_code inside {[CH_UA:CH_UZ]};
    is_lower = in_ch.char_code inside {[CH_LA:CH_LZ]};
    is_digit = in_ch.char_code inside {[CH_D0:CH_D9]};
    let_full = is_lower ? (in_ch.char_code - CH_LA) : (in_ch.char_code - CH_UA);
    keep     = in_ch.has_char && (is_upper || is_lower) &&
               (cnt_r < IDX_W'(MAX_LETTERS));
    cnt_new  = keep ? (cnt_r + IDX_W'(1)) : cnt_r;
    dig_new  = (in_ch.has_char && !first_r) ? is_digit : digit_r;
  end

  assign let_we   = in_acc && keep;
  assign let_addr = (state_r == S_IDLE) ? cnt_r[ADDR_W-1:0] : i_r[ADDR_W-1:0];
  assign fwd_we   = (state_r == S_SCAN) && !used_r[idx_r[ADDR_W-1:0]] && (v_r == '0);
  assign inv_we   = fwd_we;
  assign inv_addr = (state_r == S_SCAN) ? idx_r[ADDR_W-1:0] : i_r[ADDR_W-1:0];

  ktp_ram #(.WIDTH(LET_W), .DEPTH(MAX_LETTERS)) u_letter_ram (
    .clk(clk), .we(let_we), .addr(let_addr), .wdata(let_full[LET_W-1:0]),
    .rdata(let_rdata)
  );

  ktp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LETTERS)) u_fwd_ram (
    .clk(clk), .we(fwd_we), .addr(i_r[ADDR_W-1:0]), .wdata(idx_r), .rdata(fwd_rdata)
  );

  ktp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LETTERS)) u_inv_ram (
    .clk(clk), .we(inv_we), .addr(inv_addr), .wdata(i_r), .rdata(inv_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    digit_nxt     = digit_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    left_nxt      = left_r;
    v_nxt         = v_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_fwd_nxt   = out_fwd_r;
    out_inv_nxt   = out_inv_r;
    out_len_nxt   = out_len_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = cnt_new;
          first_nxt = first_r || in_ch.has_char;
          digit_nxt = dig_new;
          if (in_ch.end_of_key) begin
            cnt_nxt   = '0;
            first_nxt = 1'b0;
            digit_nxt = 1'b0;
            n_nxt     = cnt_new;
            i_nxt     = '0;
            left_nxt  = cnt_new;
            used_nxt  = '0;
            if (dig_new) begin
              st_nxt    = ST_NUMERIC;
              state_nxt = S_SINGLE;
            end else if (cnt_new == '0) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_SINGLE;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        v_nxt     = let_rdata;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (IDX_W'(v_r) >= left_r) begin
          v_nxt = LET_W'(IDX_W'(v_r) - left_r);
        end else begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (!used_r[idx_r[ADDR_W-1:0]]) begin
          if (v_r == '0) begin
            used_nxt[idx_r[ADDR_W-1:0]] = 1'b1;
            left_nxt = left_r - IDX_W'(1);
            if (i_inc == n_r) begin
              i_nxt     = '0;
              state_nxt = S_ORD;
            end else begin
              i_nxt     = i_inc;
              state_nxt = S_RD;
            end
          end else begin
            v_nxt = v_r - LET_W'(1);
          end
        end
      end
      S_ORD: begin
        state_nxt = S_OLOAD;
      end
      S_OLOAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = i_r;
          out_fwd_nxt   = fwd_rdata;
          out_inv_nxt   = inv_rdata;
          out_len_nxt   = n_r;
          out_st_nxt    = ST_OK;
          out_last_nxt  = (i_inc == n_r);
          if (i_inc == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_ORD;
          end
        end
      end
      S_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = '0;
          out_fwd_nxt   = '0;
          out_inv_nxt   = '0;
          out_len_nxt   = '0;
          out_st_nxt    = st_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      digit_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      digit_r     <= digit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    left_r     <= left_nxt;
    v_r        <= v_nxt;
    idx_r      <= idx_nxt;
    used_r     <= used_nxt;
    st_r       <= st_nxt;
    out_pos_r  <= out_pos_nxt;
    out_fwd_r  <= out_fwd_nxt;
    out_inv_r  <= out_inv_nxt;
    out_len_r  <= out_len_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.forward_value = out_fwd_r;
  assign out_ch.inverse_value = out_inv_r;
  assign out_ch.perm_length   = out_len_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.last_result   = out_last_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < n_r)
    else $error("scan ran past the permutation length");

  a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOD |-> left_r != '0)
    else $error("modulo by zero remaining entries");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IDX_W'(MAX_LETTERS))
    else $error("letter count above limit");

  a_special_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.last_result)
    else $error("special status item not marked last");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OLOAD |-> $countones(used_r) == int'(n_r))
    else $error("used index count differs from permutation length");
endmodule

>>> verif/ktp_checker.sv
// Checker for the keyword to permutation block: watches both channels, predicts and compares.
module ktp_checker (
  input  logic clk,
  input  logic rst_n,
  ktp_in_if    in_ch,
  ktp_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ktp_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] forward_value;
    logic [IDX_W-1:0] inverse_value;
    logic [IDX_W-1:0] perm_length;
    logic [ST_W-1:0]  status;
    logic             last_result;
  } perm_entry_t;

  perm_entry_t      expected_perm_q[$];
  logic [LET_W-1:0] kept_letters[MAX_LETTERS];
  int               kept_count;
  bit               key_open;
  bit               digit_led;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic perm_entry_t make_entry(int pos, int fwd, int inv, int len,
                                             logic [ST_W-1:0] st, bit last);
    perm_entry_t e;
    e.position      = IDX_W'(pos);
    e.forward_value = IDX_W'(fwd);
    e.inverse_value = IDX_W'(inv);
    e.perm_length   = IDX_W'(len);
    e.status        = st;
    e.last_result   = last;
    return e;
  endfunction

  function automatic void unrank_key();
    int unused_q[$];
    int fwd_tab[MAX_LETTERS];
    int inv_tab[MAX_LETTERS];
    int n;
    int j;
    n = kept_count;
    if (digit_led) begin
      expected_perm_q.push_back(make_entry(0, 0, 0, 0, ST_NUMERIC, 1'b1));
    end else if (n == 0) begin
      expected_perm_q.push_back(make_entry(0, 0, 0, 0, ST_EMPTY, 1'b1));
    end else begin
      for (int i = 0; i < n; i++) unused_q.push_back(i);
      for (int i = 0; i < n; i++) begin
        j = int'(kept_letters[i]) % (n - i);
        fwd_tab[i] = unused_q[j];
        unused_q.delete(j);
        inv_tab[fwd_tab[i]] = i;
      end
      for (int i = 0; i < n; i++) begin
        expected_perm_q.push_back(make_entry(i, fwd_tab[i], inv_tab[i], n, ST_OK, i == n - 1));
      end
    end
  endfunction

  function automatic void take_key_byte(logic [7:0] c, logic has, logic last);
    if (has) begin
      if (!key_open) begin
        key_open  = 1'b1;
        digit_led = (c >= CH_D0 && c <= CH_D9);
      end
      if (c >= CH_LA && c <= CH_LZ) c = c - (CH_LA - CH_UA);
      if (c >= CH_UA && c <= CH_UZ && kept_count < MAX_LETTERS) begin
        kept_letters[kept_count] = LET_W'(c - CH_UA);
        kept_count++;
      end
    end
    if (last) begin
      unrank_key();
      kept_count = 0;
      key_open   = 1'b0;
      digit_led  = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    perm_entry_t want;
    if (!rst_n) begin
      expected_perm_q.delete();
      kept_count = 0;
      key_open   = 1'b0;
      digit_led  = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_perm_q.size() == 0) begin
          $error("unexpected result item at position %0d", out_ch.position);
          fail_count++;
        end else begin
          want = expected_perm_q.pop_front();
          check_field("position", 8'(want.position), 8'(out_ch.position));
          check_field("forward_value", 8'(want.forward_value), 8'(out_ch.forward_value));
          check_field("inverse_value", 8'(want.inverse_value), 8'(out_ch.inverse_value));
          check_field("perm_length", 8'(want.perm_length), 8'(out_ch.perm_length));
          check_field("status", 8'(want.status), 8'(out_ch.status));
          check_field("last_result", 8'(want.last_result), 8'(out_ch.last_result));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        take_key_byte(in_ch.char_code, in_ch.has_char, in_ch.end_of_key);
      end
    end
    pending = expected_perm_q.size();
  end

endmodule

>>> verif/tb_keyword_to_permutation_top.sv
// Testbench top for the keyword to permutation block: clock, reset, key stimulus and verdict.
module tb_keyword_to_permutation_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ktp_pkg::*;

  logic clk;
  logic rst_n;
  int   checker_fails;
  int   results_pending;
  int   items_sent;
  int   in_idle_pct;
  int   out_idle_pct;
  bit   hold_req;

  ktp_in_if  in_ch();
  ktp_out_if out_ch();

  keyword_to_permutation_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ktp_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (checker_fails),
    .pending    (results_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] any_letter();
    return ($urandom_range(1) ? CH_LA : CH_UA) + 8'($urandom_range(25));
  endfunction

  // fold letters onto control codes and punctuation/digits
  function automatic logic [7:0] non_letter();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ)) c = c ^ 8'h40;
    return c;
  endfunction

  task automatic key_byte(logic [7:0] c, bit has, bit last);
    items_sent++;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_code  <= c;
    in_ch.has_char   <= has;
    in_ch.end_of_key <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_key(bit force_long);
    int  roll;
    int  len;
    bit  lead_digit;
    bit  split_end;
    logic [7:0] c;
    roll = $urandom_range(99);
    if (roll < 7) begin
      // noise: raw bytes with random has_char
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        key_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      end
      key_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      return;
    end
    if (roll < 11) len = 0;
    else if (roll < 21 || force_long) len = $urandom_range(20, 32);
    else len = $urandom_range(1, 8);
    lead_digit = ($urandom_range(99) < 10);
    split_end  = ($urandom_range(99) < 30) || (len == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) key_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      if (i == 0 && lead_digit) c = CH_D0 + 8'($urandom_range(9));
      else if ($urandom_range(99) < 80) c = any_letter();
      else c = non_letter();
      key_byte(c, 1'b1, !split_end && i == len - 1);
    end
    if (split_end) key_byte(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 599;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int keys;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = 8'h00;
    in_ch.has_char   = 1'b0;
    in_ch.end_of_key = 1'b0;
    items_sent       = 0;
    in_idle_pct      = 35;
    out_idle_pct     = 35;
    hold_req         = 1'b0;
    keys             = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bare end marker carrying a digit: empty key
    key_byte(CH_D0, 1'b0, 1'b1);
    // leading digit: numeric key
    key_byte(CH_D9, 1'b1, 1'b0);
    key_byte(CH_LA, 1'b1, 1'b1);
    key_byte(CH_D0, 1'b1, 1'b1);
    // bare item, then a non-letter lead before letters
    key_byte(CH_UA, 1'b0, 1'b0);
    key_byte(8'h25, 1'b1, 1'b0);
    key_byte(CH_LA, 1'b1, 1'b0);
    key_byte(CH_UZ, 1'b1, 1'b1);
    // high bytes are dropped
    key_byte(8'hFF, 1'b1, 1'b0);
    key_byte(8'h80, 1'b1, 1'b0);
    key_byte(CH_LZ, 1'b1, 1'b1);
    key_byte(CH_UA, 1'b1, 1'b1);
    // end marker on its own item
    key_byte(CH_LZ, 1'b1, 1'b0);
    key_byte(CH_UZ, 1'b1, 1'b0);
    key_byte(CH_LA, 1'b1, 1'b0);
    key_byte(CH_UA, 1'b1, 1'b0);
    key_byte(CH_UZ, 1'b0, 1'b1);
    // digit after a letter is just dropped
    key_byte(8'h71, 1'b1, 1'b0);
    key_byte(CH_D9, 1'b1, 1'b1);
    // neighbours of the letter and digit ranges, nothing kept
    key_byte(8'h2F, 1'b1, 1'b0);
    key_byte(8'h40, 1'b1, 1'b0);
    key_byte(8'h5B, 1'b1, 1'b0);
    key_byte(8'h60, 1'b1, 1'b0);
    key_byte(8'h7B, 1'b1, 1'b0);
    key_byte(8'h3A, 1'b1, 1'b0);
    key_byte(8'h00, 1'b0, 1'b1);

    while (items_sent < 104) begin
      if (items_sent >= 40 && items_sent < 70) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 35;
        out_idle_pct = 35;
      end
      if (items_sent >= 75) hold_req = 1'b1;
      random_key(keys == 0);
      keys++;
    end
    in_ch.valid <= 1'b0;

    while (results_pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (checker_fails == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
